/* design/phase_rotation_detector_defines.svh */
// ----------------------------------------------------------------------------
// Phase rotation detector assertion macros
// Concurrent check helpers, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PHASE_ROTATION_DETECTOR_DEFINES_SVH
`define PHASE_ROTATION_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define PRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PRD_ASSERT_IMP(lbl, ante, cons, msg)
`define PRD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* design/prd_pkg.sv */
// ----------------------------------------------------------------------------
// Phase rotation detector package
// Shared constants, tracker control bundle and the cyclic order check.
// ----------------------------------------------------------------------------
package prd_pkg;

    // Window position width and configuration register width
    localparam int POS_BITS = 8;
    localparam int CFG_BITS = 8;

    // Window length after reset
    localparam logic [CFG_BITS-1:0] CFG_WINDOW_RESET = 8'd70;

    // Control from the window sequencer to each phase tracker
    typedef struct packed {
        logic                adv;    // a sample moves into the tracker
        logic                last;   // that sample closes the window
        logic [POS_BITS-1:0] index;  // its position within the window
    } trk_ctrl_t;

    // True when positions are distinct and in cyclic order R, Y, B
    function automatic logic cyclic_ryb(
        input logic [POS_BITS-1:0] r,
        input logic [POS_BITS-1:0] y,
        input logic [POS_BITS-1:0] b
    );
        cyclic_ryb = ((r < y) && (y < b)) ||
                     ((y < b) && (b < r)) ||
                     ((b < r) && (r < y));
    endfunction

endpackage

/* design/phase_rotation_detector.sv */
// ----------------------------------------------------------------------------
// Phase rotation detector
// Per-window peak tracking of three phase samples and R-Y-B order check.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents (low bits first)
//  -------  ---------  -------------------------------------------------------
//  s_       in         sample_r, sample_y, sample_b
//  m_       out        sequence_ok, peak_r, peak_y, peak_b,
//                      position_r, position_y, position_b
//  cfg_     in         samples_per_window (write only)
//
//  One sample triple per cycle. A triple is held in the input register,
//  then updates the trackers; a window's result is in the output
//  register the cycle after its last triple leaves the input register.
//  Reset clears the trackers, the window index and both valid flags and
//  loads a window length of 70. While a result waits on m_tready, triples
//  that do not close a window keep flowing; a closing triple waits.
//
`include "phase_rotation_detector_defines.svh"

module phase_rotation_detector #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [((3 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                           s_tdata,   // sample_r, sample_y, sample_b
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [((1 + 3 * SAMPLE_BITS + 3 * prd_pkg::POS_BITS + 7) / 8) * 8 - 1:0]
                                           m_tdata,   // sequence_ok, peak_r, peak_y,
                                                      // peak_b, position_r,
                                                      // position_y, position_b
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [prd_pkg::CFG_BITS-1:0]   cfg_wr_data  // samples_per_window
);

    localparam int IN_USED  = 3 * SAMPLE_BITS;
    localparam int OUT_USED = 1 + 3 * SAMPLE_BITS + 3 * prd_pkg::POS_BITS;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
    localparam int PB       = prd_pkg::POS_BITS;

    logic                          in_valid;
    logic [IN_USED-1:0]            in_data;
    logic                          consume;
    logic                          win_last;
    logic                          out_free;
    logic [PB-1:0]                 index_reg;
    logic [PB-1:0]                 index_next;
    logic [prd_pkg::CFG_BITS-1:0]  window_reg;
    logic                          out_valid_reg;
    logic [OUT_USED-1:0]           out_data_reg;
    prd_pkg::trk_ctrl_t            ctrl;
    logic [SAMPLE_BITS-1:0]        peak_r_next;
    logic [SAMPLE_BITS-1:0]        peak_y_next;
    logic [SAMPLE_BITS-1:0]        peak_b_next;
    logic [PB-1:0]                 pos_r_next;
    logic [PB-1:0]                 pos_y_next;
    logic [PB-1:0]                 pos_b_next;
    logic                          seq_ok;

    // Input register
    prd_in_reg #(
        .DATA_W (IN_USED)
    ) u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_data   (s_tdata[IN_USED-1:0]),
        .take     (consume),
        .valid    (in_valid),
        .data     (in_data)
    );

    // Window sequencing: closing triples need a free output register
    always_comb begin
        out_free   = !out_valid_reg || m_tready;
        win_last   = ({1'b0, index_reg} + 9'd1) >= {1'b0, window_reg};
        consume    = in_valid && (!win_last || out_free);
        index_next = index_reg + 8'd1;
        ctrl.adv   = consume;
        ctrl.last  = win_last;
        ctrl.index = index_reg;
    end

    // Per-phase trackers
    prd_phase_trk #(.SAMPLE_BITS(SAMPLE_BITS)) u_trk_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample    (in_data[SAMPLE_BITS-1:0]),
        .peak_next (peak_r_next),
        .pos_next  (pos_r_next)
    );

    prd_phase_trk #(.SAMPLE_BITS(SAMPLE_BITS)) u_trk_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample    (in_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .peak_next (peak_y_next),
        .pos_next  (pos_y_next)
    );

    prd_phase_trk #(.SAMPLE_BITS(SAMPLE_BITS)) u_trk_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample    (in_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .peak_next (peak_b_next),
        .pos_next  (pos_b_next)
    );

    assign seq_ok = prd_pkg::cyclic_ryb(pos_r_next, pos_y_next, pos_b_next);

    // Window index and length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg  <= '0;
            window_reg <= prd_pkg::CFG_WINDOW_RESET;
        end else begin
            if (consume) begin
                index_reg <= win_last ? '0 : index_next;
            end
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && win_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (consume && win_last) begin
            out_data_reg <= {pos_b_next, pos_y_next, pos_r_next,
                             peak_b_next, peak_y_next, peak_r_next, seq_ok};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    // Checks
    `PRD_ASSERT_IMP(a_no_overwrite, m_tvalid && !m_tready, !(consume && win_last), "result overwritten while stalled")
    `PRD_ASSERT_NXT(a_result_loaded, consume && win_last, m_tvalid && (index_reg == '0), "window close did not load result")
    `PRD_ASSERT_NXT(a_index_step, consume && !win_last, index_reg == PB'($past(index_reg) + 8'd1), "window index did not advance")
    `PRD_ASSERT_NXT(a_index_hold, !consume, index_reg == $past(index_reg), "window index moved without a transfer")

endmodule

/* design/prd_in_reg.sv */
// ----------------------------------------------------------------------------
// Phase rotation detector input register
// Holds one sample triple; refills in the cycle the held one is taken.
// ----------------------------------------------------------------------------
module prd_in_reg #(
    parameter int DATA_W = 36
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_data,
    input  logic              take,
    output logic              valid,
    output logic [DATA_W-1:0] data
);

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;

    // Free when empty or being drained this cycle
    assign s_tready = !valid_reg || take;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_data;
        end
    end

endmodule

/* design/prd_phase_trk.sv */
// ----------------------------------------------------------------------------
// Phase rotation detector per-phase peak tracker
// Running maximum and the window position of its first occurrence.
// ----------------------------------------------------------------------------
module prd_phase_trk #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  prd_pkg::trk_ctrl_t            ctrl,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic [SAMPLE_BITS-1:0]        peak_next,
    output logic [prd_pkg::POS_BITS-1:0]  pos_next
);

    logic [SAMPLE_BITS-1:0]       max_reg;
    logic [prd_pkg::POS_BITS-1:0] pos_reg;
    logic                         hit;

    // Strictly greater only: equal later samples keep the first position
    always_comb begin
        hit       = max_reg < sample;
        peak_next = hit ? sample : max_reg;
        pos_next  = hit ? ctrl.index : pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= '0;
            pos_reg <= '0;
        end else if (ctrl.adv) begin
            if (ctrl.last) begin
                max_reg <= '0;
                pos_reg <= '0;
            end else begin
                max_reg <= peak_next;
                pos_reg <= pos_next;
            end
        end
    end

endmodule

/* bench/phase_rotation_detector_tb.sv */
// ----------------------------------------------------------------------------
// Phase rotation detector testbench
// Streams sample triples into the detector and checks every window result
// against a local model of the peak trackers. Starts at the reset window
// length, then runs directed windows, short and extreme lengths, length
// changes inside a window, an output-side hold-off, and randomized phases
// of three-phase waveforms mixed with noise.
// ----------------------------------------------------------------------------
module phase_rotation_detector_tb;

    localparam int SMP_W       = 12;
    localparam int IN_BITS     = 40;   // 36 bits of samples, padded to bytes
    localparam int OUT_BITS    = 64;   // 61 bits of result, padded to bytes
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;

    // Window result, lowest field last so it lines up with m_tdata
    typedef struct packed {
        logic [prd_pkg::POS_BITS-1:0] pos_b;
        logic [prd_pkg::POS_BITS-1:0] pos_y;
        logic [prd_pkg::POS_BITS-1:0] pos_r;
        logic [SMP_W-1:0]             peak_b;
        logic [SMP_W-1:0]             peak_y;
        logic [SMP_W-1:0]             peak_r;
        logic                         seq_ok;
    } window_result_t;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [IN_BITS-1:0]             s_tdata     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [OUT_BITS-1:0]            m_tdata;
    logic                           cfg_wr_en   = 1'b0;
    logic [prd_pkg::CFG_BITS-1:0]   cfg_wr_data = '0;

    // Stimulus and expectation stores
    logic [3*SMP_W-1:0]    sample_q[$];
    window_result_t        pending_windows[$];
    int                    sent_count     = 0;
    int                    accepted_count = 0;
    int                    mismatches     = 0;
    int                    cycle_count    = 0;

    // Idle control
    bit                    no_idle     = 1'b0;
    int                    s_gap       = 0;
    int                    rdy_gap     = 0;
    int                    hold_req    = 0;
    int                    hold_seen   = 0;
    int                    hold_left   = 0;
    bit                    hold_active = 1'b0;

    // Local tracker model
    logic [prd_pkg::CFG_BITS-1:0] win_len = prd_pkg::CFG_WINDOW_RESET;
    logic [prd_pkg::POS_BITS-1:0] win_idx = '0;
    logic [SMP_W-1:0]             run_max_r = '0, run_max_y = '0, run_max_b = '0;
    logic [prd_pkg::POS_BITS-1:0] first_pos_r = '0, first_pos_y = '0, first_pos_b = '0;

    phase_rotation_detector u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Distinct positions in cyclic order R, Y, B
    function automatic logic rotation_ok(input logic [prd_pkg::POS_BITS-1:0] r,
                                         input logic [prd_pkg::POS_BITS-1:0] y,
                                         input logic [prd_pkg::POS_BITS-1:0] b);
        if (r < y && y < b) return 1'b1;
        if (y < b && b < r) return 1'b1;
        if (b < r && r < y) return 1'b1;
        return 1'b0;
    endfunction

    // Fold one accepted triple into the trackers, close the window if due
    task automatic track_sample(input logic [SMP_W-1:0] sr,
                                input logic [SMP_W-1:0] sy,
                                input logic [SMP_W-1:0] sb);
        window_result_t res;
        if (run_max_r < sr) begin
            run_max_r   = sr;
            first_pos_r = win_idx;
        end
        if (run_max_y < sy) begin
            run_max_y   = sy;
            first_pos_y = win_idx;
        end
        if (run_max_b < sb) begin
            run_max_b   = sb;
            first_pos_b = win_idx;
        end
        if (int'(win_idx) + 1 >= int'(win_len)) begin
            res.seq_ok = rotation_ok(first_pos_r, first_pos_y, first_pos_b);
            res.peak_r = run_max_r;
            res.peak_y = run_max_y;
            res.peak_b = run_max_b;
            res.pos_r  = first_pos_r;
            res.pos_y  = first_pos_y;
            res.pos_b  = first_pos_b;
            pending_windows.push_back(res);
            win_idx   = '0;
            run_max_r = '0;
            run_max_y = '0;
            run_max_b = '0;
            first_pos_r = '0;
            first_pos_y = '0;
            first_pos_b = '0;
        end else begin
            win_idx = win_idx + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", what, got, want));
    endtask

    task automatic check_window(input logic [OUT_BITS-1:0] data);
        window_result_t got;
        window_result_t want;
        got = data[$bits(window_result_t)-1:0];
        if (pending_windows.size() == 0) begin
            report_mismatch($sformatf("unexpected window result 0x%h", data));
        end else begin
            want = pending_windows.pop_front();
            check_field("sequence_ok", got.seq_ok, want.seq_ok);
            check_field("peak_r", got.peak_r, want.peak_r);
            check_field("peak_y", got.peak_y, want.peak_y);
            check_field("peak_b", got.peak_b, want.peak_b);
            check_field("position_r", got.pos_r, want.pos_r);
            check_field("position_y", got.pos_y, want.pos_y);
            check_field("position_b", got.pos_b, want.pos_b);
        end
    endtask

    // Input driver: predicts on each transfer, then offers the next triple
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_sample(s_tdata[SMP_W-1:0], s_tdata[2*SMP_W-1:SMP_W],
                             s_tdata[3*SMP_W-1:2*SMP_W]);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    s_tdata  <= {4'b0, sample_q.pop_front()};
                    s_tvalid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 9) == 0)
                        s_gap = $urandom_range(1, 19);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and ready generation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_gap = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_window(m_tdata);
            if (hold_active) begin
                m_tready <= 1'b0;
            end else if (rdy_gap > 0) begin
                rdy_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    rdy_gap = $urandom_range(1, 19);
            end
        end
    end

    // Long receiver hold-off, counted here on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        hold_active <= (hold_left > 0);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_sample(input int sr, input int sy, input int sb);
        sample_q.push_back({sb[SMP_W-1:0], sy[SMP_W-1:0], sr[SMP_W-1:0]});
        sent_count++;
    endtask

    // Wait until every triple is taken and every window result has come out
    task automatic wait_idle();
        while (accepted_count != sent_count || pending_windows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_window_len(input int len);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[prd_pkg::CFG_BITS-1:0];
        win_len = len[prd_pkg::CFG_BITS-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Triangle wave sample peaking where t lines up with off
    function automatic int wave_value(input int t, input int off, input int period,
                                      input int amp, input int base);
        int d;
        int fold;
        int v;
        d    = ((t - off) % period + period) % period;
        fold = (d < period - d) ? d : period - d;
        v    = base + amp - (2 * amp * fold) / period + $urandom_range(0, 2);
        if (v > 4095) v = 4095;
        if (v < 0) v = 0;
        return v;
    endfunction

    // Three-phase waveform, forward (R, Y, B) or reversed rotation
    task automatic queue_wave(input int count, input int period, input bit forward);
        int shift;
        int amp;
        int base;
        int off_y;
        int off_b;
        shift = $urandom_range(0, period - 1);
        amp   = $urandom_range(64, 2000);
        base  = $urandom_range(0, 4095 - amp - 3);
        off_y = forward ? period / 3 : (2 * period) / 3;
        off_b = forward ? (2 * period) / 3 : period / 3;
        for (int t = 0; t < count; t++)
            push_sample(wave_value(t + shift, 0, period, amp, base),
                        wave_value(t + shift, off_y, period, amp, base),
                        wave_value(t + shift, off_b, period, amp, base));
    endtask

    task automatic queue_noise(input int count);
        for (int i = 0; i < count; i++)
            push_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095));
    endtask

    // One randomized phase: new length, a few windows, a ragged tail
    task automatic random_phase();
        int len;
        int roll;
        int windows;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            len = $urandom_range(0, 2);
        else if (roll == 1)
            len = $urandom_range(25, 64);
        else
            len = $urandom_range(3, 24);
        write_window_len(len);
        windows = $urandom_range(2, 4);
        repeat (windows) begin
            if (len >= 3 && $urandom_range(0, 3) != 0)
                queue_wave(len, len, $urandom_range(0, 1));
            else
                queue_noise(len < 1 ? 1 : len);
        end
        queue_noise($urandom_range(0, len));
        wait_idle();
    endtask

    // Test sequence
    initial begin
        int rand_start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window length
        queue_wave(70, 70, 1'b1);
        wait_idle();

        // Directed windows of three
        write_window_len(3);
        // phases never above zero
        push_sample(0, 0, 0);
        push_sample(0, 0, 0);
        push_sample(0, 0, 0);
        // full scale everywhere, first position holds
        push_sample(4095, 4095, 4095);
        push_sample(4095, 4095, 4095);
        push_sample(4095, 4095, 4095);
        // later equal values do not move the peak
        push_sample(5, 0, 0);
        push_sample(5, 7, 0);
        push_sample(5, 7, 9);
        // Y, B, R rotation
        push_sample(1, 900, 2);
        push_sample(2, 3, 900);
        push_sample(900, 4, 3);
        // B, R, Y rotation
        push_sample(3, 2, 800);
        push_sample(800, 1, 4);
        push_sample(2, 800, 5);
        // reversed rotation
        push_sample(700, 1, 1);
        push_sample(2, 2, 700);
        push_sample(3, 700, 3);
        // two peaks at one position
        push_sample(600, 600, 1);
        push_sample(2, 3, 4);
        push_sample(5, 6, 600);
        // alternating bit patterns
        push_sample('h555, 'hAAA, 'h555);
        push_sample('hAAA, 'h555, 'hAAA);
        push_sample('h000, 'hFFF, 'h001);
        wait_idle();

        // Degenerate lengths
        write_window_len(0);
        queue_noise(3);
        wait_idle();
        write_window_len(1);
        queue_noise(3);
        wait_idle();
        write_window_len(2);
        queue_noise(5);
        wait_idle();

        // Shorten inside a window: next triple closes it
        write_window_len(1);
        queue_noise(2);
        wait_idle();
        write_window_len(10);
        queue_noise(6);
        wait_idle();
        write_window_len(4);
        queue_noise(3);
        wait_idle();

        // Longest window
        write_window_len(255);
        queue_wave(255, 255, 1'b1);
        wait_idle();

        // Receiver holds off while the sender keeps offering
        write_window_len(1);
        hold_req <= hold_req + 1;
        queue_noise(30);
        wait_idle();

        // Randomized phases
        rand_start = sent_count;
        while (sent_count - rand_start < 80)
            random_phase();

        // Final stretch with no idling
        no_idle <= 1'b1;
        write_window_len(12);
        queue_noise(72);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (pending_windows.size() != 0)
            report_mismatch($sformatf("%0d window results never arrived",
                                      pending_windows.size()));
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/prd_pkg.sv
design/prd_in_reg.sv
design/prd_phase_trk.sv
design/phase_rotation_detector.sv
bench/phase_rotation_detector_tb.sv
